@@ hdl/v2da_pkg.sv @@
package v2da_pkg;

   localparam logic [2:0] ACT_ADD   = 3'd0;
   localparam logic [2:0] ACT_SUB   = 3'd1;
   localparam logic [2:0] ACT_SCALE = 3'd2;
   localparam logic [2:0] ACT_LEN   = 3'd3;
   localparam logic [2:0] ACT_NORM  = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   localparam int ROOT_STEPS = 16;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic               sat;
   } root_side_type;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic               sat;
   } div_side_type;

   // {saturated, value}
   function automatic logic [16:0] sat16(input logic signed [31:0] v);
      logic [16:0] res;
      if (v > 32'sd32767) begin
         res = {1'b1, 16'h7fff};
      end else if (v < -32'sd32768) begin
         res = {1'b1, 16'h8000};
      end else begin
         res = {1'b0, v[15:0]};
      end
      return res;
   endfunction

endpackage

@@ hdl/v2da_sqrt_pipe.sv @@
module v2da_sqrt_pipe #(
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [31:0]   in_n,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [15:0]   out_root,
   output logic [SW-1:0] out_side
);

   localparam int NS = v2da_pkg::ROOT_STEPS;

   logic          v_ff    [NS];
   logic [31:0]   n_ff    [NS];
   logic [18:0]   r_ff    [NS];
   logic [15:0]   q_ff    [NS];
   logic [SW-1:0] side_ff [NS];

   for (genvar s = 0; s < NS; s++) begin : g_step
      logic          v_src;
      logic [31:0]   n_src;
      logic [18:0]   r_src;
      logic [15:0]   q_src;
      logic [SW-1:0] side_src;
      logic [18:0]   r_sh;
      logic [18:0]   trial;
      logic [18:0]   r_in;
      logic [15:0]   q_in;

      if (s == 0) begin : g_first
         assign v_src    = in_valid;
         assign n_src    = in_n;
         assign r_src    = '0;
         assign q_src    = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = v_ff[s-1];
         assign n_src    = n_ff[s-1];
         assign r_src    = r_ff[s-1];
         assign q_src    = q_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      always_comb begin
         r_sh  = {r_src[16:0], n_src[31:30]};
         trial = {1'b0, q_src, 2'b01};
         if (r_sh >= trial) begin
            r_in = r_sh - trial;
            q_in = {q_src[14:0], 1'b1};
         end else begin
            r_in = r_sh;
            q_in = {q_src[14:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_src;
         end
         if (en) begin
            n_ff[s]    <= {n_src[29:0], 2'b00};
            r_ff[s]    <= r_in;
            q_ff[s]    <= q_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_root  = q_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

@@ hdl/v2da_div_pipe.sv @@
module v2da_div_pipe #(
   parameter int FRAC_BITS = 8,
   parameter int SW        = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [15:0] in_ax,
   input  logic signed [15:0] in_ay,
   input  logic [15:0]        in_mag,
   input  logic [SW-1:0]      in_side,
   output logic               out_valid,
   output logic signed [15:0] out_qx,
   output logic signed [15:0] out_qy,
   output logic [15:0]        out_mag,
   output logic [SW-1:0]      out_side
);

   localparam int DW = 17 + FRAC_BITS;
   localparam int QW = FRAC_BITS + 1;
   localparam int NS = FRAC_BITS + 1;

   logic          v_ff    [NS];
   logic [DW-1:0] rx_ff   [NS];
   logic [DW-1:0] ry_ff   [NS];
   logic [QW-1:0] qx_ff   [NS];
   logic [QW-1:0] qy_ff   [NS];
   logic [15:0]   m_ff    [NS];
   logic          nx_ff   [NS];
   logic          ny_ff   [NS];
   logic [SW-1:0] side_ff [NS];

   logic [15:0] abs_x;
   logic [15:0] abs_y;

   assign abs_x = in_ax[15] ? 16'(-in_ax) : in_ax;
   assign abs_y = in_ay[15] ? 16'(-in_ay) : in_ay;

   for (genvar s = 0; s < NS; s++) begin : g_step
      localparam int K = FRAC_BITS - s;
      logic          v_src;
      logic [DW-1:0] rx_src;
      logic [DW-1:0] ry_src;
      logic [QW-1:0] qx_src;
      logic [QW-1:0] qy_src;
      logic [15:0]   m_src;
      logic          nx_src;
      logic          ny_src;
      logic [SW-1:0] side_src;
      logic [DW-1:0] dvs;
      logic [DW-1:0] rx_in;
      logic [DW-1:0] ry_in;
      logic [QW-1:0] qx_in;
      logic [QW-1:0] qy_in;

      if (s == 0) begin : g_first
         assign v_src    = in_valid;
         assign rx_src   = DW'(abs_x) << FRAC_BITS;
         assign ry_src   = DW'(abs_y) << FRAC_BITS;
         assign qx_src   = '0;
         assign qy_src   = '0;
         assign m_src    = in_mag;
         assign nx_src   = in_ax[15];
         assign ny_src   = in_ay[15];
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = v_ff[s-1];
         assign rx_src   = rx_ff[s-1];
         assign ry_src   = ry_ff[s-1];
         assign qx_src   = qx_ff[s-1];
         assign qy_src   = qy_ff[s-1];
         assign m_src    = m_ff[s-1];
         assign nx_src   = nx_ff[s-1];
         assign ny_src   = ny_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      always_comb begin
         dvs = DW'(m_src) << K;
         if (rx_src >= dvs) begin
            rx_in = rx_src - dvs;
            qx_in = {qx_src[QW-2:0], 1'b1};
         end else begin
            rx_in = rx_src;
            qx_in = {qx_src[QW-2:0], 1'b0};
         end
         if (ry_src >= dvs) begin
            ry_in = ry_src - dvs;
            qy_in = {qy_src[QW-2:0], 1'b1};
         end else begin
            ry_in = ry_src;
            qy_in = {qy_src[QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_src;
         end
         if (en) begin
            rx_ff[s]   <= rx_in;
            ry_ff[s]   <= ry_in;
            qx_ff[s]   <= qx_in;
            qy_ff[s]   <= qy_in;
            m_ff[s]    <= m_src;
            nx_ff[s]   <= nx_src;
            ny_ff[s]   <= ny_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_qx    = nx_ff[NS-1] ? -16'(qx_ff[NS-1]) : 16'(qx_ff[NS-1]);
   assign out_qy    = ny_ff[NS-1] ? -16'(qy_ff[NS-1]) : 16'(qy_ff[NS-1]);
   assign out_mag   = m_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

@@ hdl/vector2d_arith_unit_core.sv @@
// Fixed-point 2-D vector unit: add, subtract, scale by bx, length and normalize on signed
// vectors with FRAC_BITS fraction bits. One beat is taken every cycle the output can move;
// each beat passes through an input register, a sum-of-squares register, a 16-step
// square-root pipeline, a FRAC_BITS + 1 step divider pipeline and a result register,
// each step one register stage. A stalled result holds the whole pipeline.
module vector2d_arith_unit_core #(
   parameter int FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic signed [15:0] req_ax,
   input  logic signed [15:0] req_ay,
   input  logic signed [15:0] req_bx,
   input  logic signed [15:0] req_by,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_rx,
   output logic signed [15:0] rsp_ry,
   output logic [15:0]        rsp_magnitude,
   output logic [1:0]         rsp_status
);

   logic en;

   logic               s1_valid_ff;
   logic [2:0]         s1_action_ff;
   logic signed [15:0] s1_ax_ff;
   logic signed [15:0] s1_ay_ff;
   logic signed [15:0] s1_bx_ff;
   logic signed [15:0] s1_by_ff;
   logic [31:0]        s1_sqx_ff;
   logic [31:0]        s1_sqy_ff;
   logic signed [31:0] s1_px_ff;
   logic signed [31:0] s1_py_ff;

   logic                   s2_valid_ff;
   logic [31:0]            s2_sum_ff;
   v2da_pkg::root_side_type s2_side_ff;
   v2da_pkg::root_side_type s2_side_in;

   logic                    rt_valid;
   logic [15:0]             rt_root;
   v2da_pkg::root_side_type rt_side;
   v2da_pkg::div_side_type  dv_side_in;

   logic                   dv_valid;
   logic signed [15:0]     dv_qx;
   logic signed [15:0]     dv_qy;
   logic [15:0]            dv_mag;
   v2da_pkg::div_side_type dv_side;

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_rx_ff;
   logic signed [15:0] rsp_ry_ff;
   logic [15:0]        rsp_mag_ff;
   logic [1:0]         rsp_status_ff;
   logic signed [15:0] rsp_rx_in;
   logic signed [15:0] rsp_ry_in;
   logic [1:0]         rsp_status_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
      if (en) begin
         s1_action_ff <= req_action;
         s1_ax_ff     <= req_ax;
         s1_ay_ff     <= req_ay;
         s1_bx_ff     <= req_bx;
         s1_by_ff     <= req_by;
         s1_sqx_ff    <= 32'(req_ax * req_ax);
         s1_sqy_ff    <= 32'(req_ay * req_ay);
         s1_px_ff     <= 32'(req_ax * req_bx);
         s1_py_ff     <= 32'(req_ay * req_bx);
      end
   end

   always_comb begin
      logic [16:0] sx;
      logic [16:0] sy;
      sx = '0;
      sy = '0;
      case (s1_action_ff)
         v2da_pkg::ACT_ADD: begin
            sx = v2da_pkg::sat16(32'(s1_ax_ff) + 32'(s1_bx_ff));
            sy = v2da_pkg::sat16(32'(s1_ay_ff) + 32'(s1_by_ff));
         end
         v2da_pkg::ACT_SUB: begin
            sx = v2da_pkg::sat16(32'(s1_ax_ff) - 32'(s1_bx_ff));
            sy = v2da_pkg::sat16(32'(s1_ay_ff) - 32'(s1_by_ff));
         end
         v2da_pkg::ACT_SCALE: begin
            sx = v2da_pkg::sat16(s1_px_ff >>> FRAC_BITS);
            sy = v2da_pkg::sat16(s1_py_ff >>> FRAC_BITS);
         end
         default: begin
            sx = '0;
            sy = '0;
         end
      endcase
      s2_side_in.action = s1_action_ff;
      s2_side_in.ax     = s1_ax_ff;
      s2_side_in.ay     = s1_ay_ff;
      s2_side_in.rx     = sx[15:0];
      s2_side_in.ry     = sy[15:0];
      s2_side_in.sat    = sx[16] | sy[16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_sum_ff  <= s1_sqx_ff + s1_sqy_ff;
         s2_side_ff <= s2_side_in;
      end
   end

   v2da_sqrt_pipe #(
      .SW($bits(v2da_pkg::root_side_type))
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s2_valid_ff),
      .in_n     (s2_sum_ff),
      .in_side  (s2_side_ff),
      .out_valid(rt_valid),
      .out_root (rt_root),
      .out_side (rt_side)
   );

   always_comb begin
      dv_side_in.action = rt_side.action;
      dv_side_in.rx     = rt_side.rx;
      dv_side_in.ry     = rt_side.ry;
      dv_side_in.sat    = rt_side.sat;
   end

   v2da_div_pipe #(
      .FRAC_BITS(FRAC_BITS),
      .SW       ($bits(v2da_pkg::div_side_type))
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (rt_valid),
      .in_ax    (rt_side.ax),
      .in_ay    (rt_side.ay),
      .in_mag   (rt_root),
      .in_side  (dv_side_in),
      .out_valid(dv_valid),
      .out_qx   (dv_qx),
      .out_qy   (dv_qy),
      .out_mag  (dv_mag),
      .out_side (dv_side)
   );

   always_comb begin
      if (dv_side.action == v2da_pkg::ACT_NORM) begin
         if (dv_mag == 16'd0) begin
            rsp_rx_in     = '0;
            rsp_ry_in     = '0;
            rsp_status_in = v2da_pkg::ST_ZERO;
         end else begin
            rsp_rx_in     = dv_qx;
            rsp_ry_in     = dv_qy;
            rsp_status_in = v2da_pkg::ST_OK;
         end
      end else begin
         rsp_rx_in     = dv_side.rx;
         rsp_ry_in     = dv_side.ry;
         rsp_status_in = dv_side.sat ? v2da_pkg::ST_SAT : v2da_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
      if (en) begin
         rsp_rx_ff     <= rsp_rx_in;
         rsp_ry_ff     <= rsp_ry_in;
         rsp_mag_ff    <= dv_mag;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rx        = rsp_rx_ff;
   assign rsp_ry        = rsp_ry_ff;
   assign rsp_magnitude = rsp_mag_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

@@ hdl/v2da_checker.sv @@
module v2da_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_rx,
   input logic signed [15:0] rsp_ry,
   input logic [15:0]        rsp_magnitude,
   input logic [1:0]         rsp_status
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rx) && $stable(rsp_ry)
         && $stable(rsp_magnitude) && $stable(rsp_status))
      else $error("result beat changed while stalled");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == v2da_pkg::ST_ZERO |->
         rsp_rx == 16'sd0 && rsp_ry == 16'sd0 && rsp_magnitude == 16'd0)
      else $error("zero-vector beat with non-zero fields");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind vector2d_arith_unit_core v2da_checker u_v2da_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_rx       (rsp_rx),
   .rsp_ry       (rsp_ry),
   .rsp_magnitude(rsp_magnitude),
   .rsp_status   (rsp_status)
);

@@ dv/vector2d_arith_unit_core_tb.sv @@
module vector2d_arith_unit_core_tb;

   localparam int FRAC = 8;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic [15:0]        magnitude;
      logic [1:0]         status;
   } vec_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_action = v2da_pkg::ACT_ADD;
   logic signed [15:0] req_ax = '0;
   logic signed [15:0] req_ay = '0;
   logic signed [15:0] req_bx = '0;
   logic signed [15:0] req_by = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_rx;
   logic signed [15:0] rsp_ry;
   logic [15:0]        rsp_magnitude;
   logic [1:0]         rsp_status;

   vec_result_type expected_q[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_req = 0;
   int hold_ack = 0;
   int hold_cnt = 0;
   int quiet_cycles = 0;

   vector2d_arith_unit_core #(.FRAC_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_ax(req_ax), .req_ay(req_ay), .req_bx(req_bx), .req_by(req_by),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_rx(rsp_rx), .rsp_ry(rsp_ry),
      .rsp_magnitude(rsp_magnitude), .rsp_status(rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp16(input longint v, inout bit sat);
      if (v > 32767) begin
         sat = 1'b1;
         return 32767;
      end
      if (v < -32768) begin
         sat = 1'b1;
         return -32768;
      end
      return v;
   endfunction

   function automatic longint int_sqrt(input longint n);
      longint r;
      r = 0;
      for (longint b = longint'(1) << 16; b > 0; b = b >> 1)
         if ((r + b) * (r + b) <= n) r = r + b;
      return r;
   endfunction

   function automatic vec_result_type vector_op(input logic [2:0] act,
                                                input logic signed [15:0] ax,
                                                input logic signed [15:0] ay,
                                                input logic signed [15:0] bx,
                                                input logic signed [15:0] by);
      vec_result_type res;
      longint x, y, mag;
      bit sat;
      logic [1:0] st;
      sat = 1'b0;
      st = v2da_pkg::ST_OK;
      x = 0;
      y = 0;
      mag = int_sqrt(longint'(ax) * ax + longint'(ay) * ay);
      case (act)
         v2da_pkg::ACT_ADD: begin
            x = clamp16(longint'(ax) + bx, sat);
            y = clamp16(longint'(ay) + by, sat);
         end
         v2da_pkg::ACT_SUB: begin
            x = clamp16(longint'(ax) - bx, sat);
            y = clamp16(longint'(ay) - by, sat);
         end
         v2da_pkg::ACT_SCALE: begin
            x = clamp16((longint'(ax) * bx) >>> FRAC, sat);
            y = clamp16((longint'(ay) * bx) >>> FRAC, sat);
         end
         v2da_pkg::ACT_NORM: begin
            if (mag == 0) begin
               st = v2da_pkg::ST_ZERO;
            end else begin
               x = (longint'(ax) * (longint'(1) << FRAC)) / mag;
               y = (longint'(ay) * (longint'(1) << FRAC)) / mag;
            end
         end
         default: ;
      endcase
      if (sat) st = v2da_pkg::ST_SAT;
      res.rx = x[15:0];
      res.ry = y[15:0];
      res.magnitude = mag[15:0];
      res.status = st;
      return res;
   endfunction

   always @(posedge clock) begin
      vec_result_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (req_valid && req_ready)
            expected_q.push_back(vector_op(req_action, req_ax, req_ay, req_bx, req_by));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result rx=%0d ry=%0d mag=%0d st=%0d", $time,
                        rsp_rx, rsp_ry, rsp_magnitude, rsp_status);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_rx !== want.rx) begin
                  $display("%0t: rx expected %0d actual %0d", $time, want.rx, rsp_rx);
                  errors++;
               end
               if (rsp_ry !== want.ry) begin
                  $display("%0t: ry expected %0d actual %0d", $time, want.ry, rsp_ry);
                  errors++;
               end
               if (rsp_magnitude !== want.magnitude) begin
                  $display("%0t: magnitude expected %0d actual %0d", $time,
                           want.magnitude, rsp_magnitude);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_status);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_cnt <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic [2:0] act, input logic signed [15:0] ax,
                            input logic signed [15:0] ay, input logic signed [15:0] bx,
                            input logic signed [15:0] by);
      int gap;
      req_valid <= 1'b1;
      req_action <= act;
      req_ax <= ax;
      req_ay <= ay;
      req_bx <= bx;
      req_by <= by;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 200) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(3))
         0: return 16'($urandom_range(1023)) - 16'sd512;
         1: case ($urandom_range(6))
               0: return 16'sh7fff;
               1: return 16'sh8000;
               2: return 16'sd0;
               3: return 16'sd1;
               4: return -16'sd1;
               5: return 16'sd256;
               default: return -16'sd256;
            endcase
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      send_item(v2da_pkg::ACT_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
      send_item(v2da_pkg::ACT_ADD, 16'sd100, -16'sd200, 16'sd300, 16'sd50);
      send_item(v2da_pkg::ACT_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
      send_item(v2da_pkg::ACT_SUB, 16'sd0, 16'sd0, 16'sh8000, 16'sd1);
      send_item(v2da_pkg::ACT_SCALE, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sd0);
      send_item(v2da_pkg::ACT_SCALE, 16'sd1234, -16'sd999, 16'sd256, 16'sh7fff);
      send_item(v2da_pkg::ACT_SCALE, -16'sd1, 16'sd1, 16'sd1, 16'sd0);
      send_item(v2da_pkg::ACT_SCALE, 16'sh7fff, 16'sh8000, -16'sd256, 16'sd0);
      send_item(v2da_pkg::ACT_LEN, 16'sd0, 16'sd0, 16'sd5, 16'sd5);
      send_item(v2da_pkg::ACT_LEN, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0);
      send_item(v2da_pkg::ACT_LEN, 16'sd768, 16'sd1024, 16'sh7fff, 16'sh8000);
      send_item(v2da_pkg::ACT_NORM, 16'sd0, 16'sd0, 16'sd7, 16'sd7);
      send_item(v2da_pkg::ACT_NORM, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0);
      send_item(v2da_pkg::ACT_NORM, 16'sd3, 16'sd4, 16'sd0, 16'sd0);
      send_item(v2da_pkg::ACT_NORM, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0);
      send_item(v2da_pkg::ACT_NORM, -16'sd1, 16'sd0, 16'sd0, 16'sd0);
      send_item(3'd5, 16'sd300, 16'sd400, 16'sd1, 16'sd1);
      send_item(3'd6, 16'sh8000, 16'sd1, 16'sh7fff, 16'sh8000);
      send_item(3'd7, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
   endtask

   task automatic test_random(input int n, input int idle_pct, input int stall_pct);
      logic [2:0] act;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (n) begin
         act = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
         send_item(act, pick_value(), pick_value(), pick_value(), pick_value());
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      hold_req = hold_req + 1;
      repeat (80)
         send_item(3'($urandom_range(4)), pick_value(), pick_value(), pick_value(),
                   pick_value());
   endtask

   task automatic test_drain_pause();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      send_item(v2da_pkg::ACT_NORM, 16'sd5, -16'sd12, 16'sd0, 16'sd0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300, 0, 0);
      test_backpressure();
      test_drain_pause();
      test_random(250, 83, 0);
      test_random(250, 0, 83);
      test_random(250, 38, 38);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
